// ===== sv/move_order_history_table_assert.svh =====
// Assertion macros for the move order history table.
// Depends on a clock named clock and a reset named reset in the including module.
`ifndef MOVE_ORDER_HISTORY_TABLE_ASSERT_SVH
`define MOVE_ORDER_HISTORY_TABLE_ASSERT_SVH

// Same-cycle implication.
`define MOHT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("move order history table: same-cycle check failed");

// Next-cycle implication.
`define MOHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("move order history table: next-cycle check failed");

`endif

// ===== sv/moht_pkg.sv =====
// Shared types and constants for the move order history table.
// No dependencies.
package moht_pkg;

   localparam int SQ_W       = 7;
   localparam int SLOT_W     = 6;
   localparam int LIST_W     = 7;
   localparam int SLOTS      = 64;
   localparam int LISTS      = 128;
   localparam int ENTRIES    = LISTS * SLOTS;
   localparam int ENTRY_AW   = LIST_W + SLOT_W;
   localparam logic [SQ_W-1:0] INIT_LEN = 7'd60;

   typedef enum logic [2:0] {
      OP_READ_LEN   = 3'd0,
      OP_READ_ENTRY = 3'd1,
      OP_TRANSPOSE  = 3'd2,
      OP_MOVE_FRONT = 3'd3,
      OP_PRUNE      = 3'd4,
      OP_REINIT     = 3'd5
   } opcode_type;

   // Fixed priority order loaded into every list.
   localparam logic [SQ_W-1:0] PRIO_TABLE [SLOTS] = '{
      7'd1,  7'd8,  7'd57, 7'd64,
      7'd3,  7'd6,  7'd17, 7'd24, 7'd41, 7'd48, 7'd59, 7'd62,
      7'd19, 7'd22, 7'd43, 7'd46,
      7'd4,  7'd5,  7'd25, 7'd32, 7'd33, 7'd40, 7'd60, 7'd61,
      7'd20, 7'd21, 7'd27, 7'd30, 7'd35, 7'd38, 7'd44, 7'd45,
      7'd12, 7'd13, 7'd26, 7'd31, 7'd34, 7'd39, 7'd52, 7'd53,
      7'd11, 7'd14, 7'd18, 7'd23, 7'd42, 7'd47, 7'd51, 7'd54,
      7'd2,  7'd7,  7'd9,  7'd16, 7'd49, 7'd56, 7'd58, 7'd63,
      7'd10, 7'd15, 7'd50, 7'd55,
      7'd28, 7'd29, 7'd36, 7'd37
   };

endpackage

// ===== sv/moht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module moht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/move_order_history_table.sv =====
// Move order history table: serves reads, transpose, move to front, prune and reinit.
// One transaction at a time; busy stays high until its single result strobe.
// Synchronous reset starts a fill of every list (busy high throughout).
// The receiver cannot stall: rsp_valid marks the result for exactly one cycle.
// Depends on moht_pkg, moht_ram and move_order_history_table_assert.svh.
module move_order_history_table
   import moht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_opcode,
   input  logic                req_side,
   input  logic [6:0]          req_stage,
   input  logic [6:0]          req_position,
   input  logic [63:0]         req_occupied_mask,
   output logic                rsp_valid,
   output logic [SQ_W-1:0]     rsp_read_value
);

   // The sequencer drives one entry RAM port pair and one length RAM port pair.
   // Every operation drives the same read/write datapath; move to front, prune and reinit walk over slots.
   typedef enum logic [3:0] {
      ST_IDLE, ST_SWEEP, ST_CMD, ST_RD_WAIT,
      ST_TR1, ST_TR2, ST_TR3, ST_TR4,
      ST_MF1, ST_MF2, ST_MF3,
      ST_PR_LEN, ST_PR_LW, ST_PR_SCAN, ST_PR_FILL, ST_PR_NEXT
   } state_type;

   state_type             state_ff;
   opcode_type            op_ff;
   logic [LIST_W-1:0]     list_ff;
   logic [6:0]            stage_ff;
   logic [6:0]            pos_ff;
   logic [SLOT_W-1:0]     start_ff;
   logic [63:0]           occ_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [6:0]            len_ff;
   logic [6:0]            rd_ff;
   logic [6:0]            wr_ff;
   logic [SQ_W-1:0]       tmp_ff;
   logic [ENTRY_AW-1:0]   sweep_ff;
   logic                  sweep_rsp_ff;
   logic                  rsp_valid_ff;
   logic [SQ_W-1:0]       rsp_value_ff;

   logic                  e_we;
   logic [SLOT_W-1:0]     e_wslot;
   logic [SQ_W-1:0]       e_wdata;
   logic [SLOT_W-1:0]     e_rslot;
   logic [SQ_W-1:0]       e_rdata;
   logic [LIST_W-1:0]     wlist;
   logic                  l_we;
   logic [SQ_W-1:0]       l_wdata;
   logic [SQ_W-1:0]       l_rdata;

   logic                  stage_ok;
   logic                  pos_ok;
   logic                  write_ok;
   logic                  taken;
   logic [SLOT_W-1:0]     pos_m1;
   logic [SLOT_W-1:0]     pos_m2;

   assign stage_ok = (stage_ff != 7'd0) && (stage_ff <= 7'd64);
   assign pos_ok   = (pos_ff != 7'd0) && (pos_ff <= 7'd64);
   assign write_ok = stage_ok && pos_ok && (pos_ff > 7'd1);
   assign pos_m1   = SLOT_W'(pos_ff - 7'd1);
   assign pos_m2   = SLOT_W'(pos_ff - 7'd2);

   // A square is removed by prune when it is a real square and its board bit is set.
   assign taken = (e_rdata != 7'd0) && (e_rdata <= 7'd64) &&
                  occ_ff[SLOT_W'(e_rdata - 7'd1)];

   always_comb begin
      e_we    = 1'b0;
      e_wslot = '0;
      e_wdata = '0;
      e_rslot = '0;
      wlist   = list_ff;
      l_we    = 1'b0;
      l_wdata = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            e_we    = 1'b1;
            wlist   = sweep_ff[ENTRY_AW-1:SLOT_W];
            e_wslot = sweep_ff[SLOT_W-1:0];
            e_wdata = PRIO_TABLE[sweep_ff[SLOT_W-1:0]];
            l_we    = (sweep_ff[SLOT_W-1:0] == '0);
            l_wdata = INIT_LEN;
         end
         ST_CMD: begin
            e_rslot = pos_m1;
         end
         ST_TR1: begin
            e_rslot = pos_m2;
         end
         ST_TR2: begin
            e_rslot = pos_m2;
         end
         ST_TR3: begin
            e_we    = 1'b1;
            e_wslot = pos_m1;
            e_wdata = e_rdata;
         end
         ST_TR4: begin
            e_we    = 1'b1;
            e_wslot = pos_m2;
            e_wdata = tmp_ff;
         end
         ST_MF1: begin
            e_rslot = slot_ff - 6'd1;
         end
         ST_MF2: begin
            e_we    = 1'b1;
            e_wslot = slot_ff;
            e_wdata = e_rdata;
            e_rslot = slot_ff - 6'd2;
         end
         ST_MF3: begin
            e_we    = 1'b1;
            e_wslot = '0;
            e_wdata = tmp_ff;
         end
         ST_PR_SCAN: begin
            e_we    = !taken;
            e_wslot = wr_ff[SLOT_W-1:0];
            e_wdata = e_rdata;
            e_rslot = rd_ff[SLOT_W-1:0];
            // The new length is known once the last live entry has been examined.
            l_we    = (rd_ff == len_ff);
            l_wdata = taken ? wr_ff : wr_ff + 7'd1;
         end
         ST_PR_FILL: begin
            // Slots freed at the tail keep copies of the old last live entry.
            if (wr_ff < len_ff) begin
               e_we    = 1'b1;
               e_wslot = wr_ff[SLOT_W-1:0];
               e_wdata = tmp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   moht_ram #(.WIDTH(SQ_W), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr ({wlist, e_wslot}),
      .wr_data (e_wdata),
      .rd_addr ({list_ff, e_rslot}),
      .rd_data (e_rdata)
   );

   moht_ram #(.WIDTH(SQ_W), .DEPTH(LISTS)) u_length_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (wlist),
      .wr_data (l_wdata),
      .rd_addr (list_ff),
      .rd_data (l_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= opcode_type'(req_opcode);
                  list_ff  <= {req_side, SLOT_W'(req_stage - 7'd1)};
                  stage_ff <= req_stage;
                  pos_ff   <= req_position;
                  occ_ff   <= req_occupied_mask;
                  start_ff <= (req_stage == 7'd0) ? '0 : SLOT_W'(req_stage - 7'd1);
                  state_ff <= ST_CMD;
               end
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (&sweep_ff) begin
                  state_ff     <= ST_IDLE;
                  sweep_rsp_ff <= 1'b0;
                  if (sweep_rsp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_value_ff <= '0;
                  end
               end
            end
            ST_CMD: begin
               rsp_value_ff <= '0;
               unique case (op_ff)
                  OP_READ_LEN: begin
                     if (stage_ok) begin
                        state_ff <= ST_RD_WAIT;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  OP_READ_ENTRY: begin
                     if (stage_ok && pos_ok) begin
                        state_ff <= ST_RD_WAIT;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  OP_TRANSPOSE: begin
                     if (write_ok) begin
                        state_ff <= ST_TR1;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  OP_MOVE_FRONT: begin
                     if (write_ok) begin
                        slot_ff  <= pos_m1;
                        state_ff <= ST_MF1;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  OP_PRUNE: begin
                     if (stage_ff <= 7'd64) begin
                        list_ff  <= {1'b0, start_ff};
                        state_ff <= ST_PR_LEN;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  OP_REINIT: begin
                     sweep_ff     <= '0;
                     sweep_rsp_ff <= 1'b1;
                     state_ff     <= ST_SWEEP;
                  end
                  default: begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_RD_WAIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= (op_ff == OP_READ_LEN) ? l_rdata : e_rdata;
               state_ff     <= ST_IDLE;
            end
            ST_TR1: begin
               // The later entry of the pair arrives first; hold it for the last write.
               tmp_ff   <= e_rdata;
               state_ff <= ST_TR2;
            end
            ST_TR2: state_ff <= ST_TR3;
            ST_TR3: state_ff <= ST_TR4;
            ST_TR4: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= '0;
               state_ff     <= ST_IDLE;
            end
            ST_MF1: begin
               tmp_ff   <= e_rdata;
               state_ff <= ST_MF2;
            end
            ST_MF2: begin
               slot_ff <= slot_ff - 6'd1;
               if (slot_ff == 6'd1) begin
                  state_ff <= ST_MF3;
               end
            end
            ST_MF3: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= '0;
               state_ff     <= ST_IDLE;
            end
            ST_PR_LEN: state_ff <= ST_PR_LW;
            ST_PR_LW: begin
               len_ff <= l_rdata;
               rd_ff  <= 7'd1;
               wr_ff  <= '0;
               state_ff <= (l_rdata == '0) ? ST_PR_NEXT : ST_PR_SCAN;
            end
            ST_PR_SCAN: begin
               tmp_ff <= e_rdata;
               if (!taken) begin
                  wr_ff <= wr_ff + 7'd1;
               end
               if (rd_ff == len_ff) begin
                  state_ff <= ST_PR_FILL;
               end else begin
                  rd_ff <= rd_ff + 7'd1;
               end
            end
            ST_PR_FILL: begin
               if (wr_ff < len_ff) begin
                  wr_ff <= wr_ff + 7'd1;
               end else begin
                  state_ff <= ST_PR_NEXT;
               end
            end
            ST_PR_NEXT: begin
               if (list_ff[SLOT_W-1:0] == 6'd63) begin
                  if (list_ff[LIST_W-1]) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_value_ff <= '0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     list_ff  <= {1'b1, start_ff};
                     state_ff <= ST_PR_LEN;
                  end
               end else begin
                  list_ff  <= list_ff + 7'd1;
                  state_ff <= ST_PR_LEN;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_valid_ff ? rsp_value_ff : '0;

`include "move_order_history_table_assert.svh"

   // A result only appears once the sequencer has returned to idle.
   `MOHT_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy)
   // An accepted transaction makes the block busy on the next cycle.
   `MOHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A result strobe lasts a single cycle.
   `MOHT_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid)
   // Prune never scans past the live length it loaded.
   `MOHT_ASSERT_NOW(a_prune_bound, state_ff == ST_PR_SCAN, rd_ff <= len_ff && wr_ff <= rd_ff)

endmodule

// ===== verif/moht_checker.sv =====
// Checker for the move order history table: watches the command and result channels,
// predicts every read value from its own copy of the lists, and counts mismatches.
// Depends on moht_pkg.
`timescale 1ns / 100ps

module moht_checker
   import moht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [2:0]       req_opcode,
   input  logic             req_side,
   input  logic [6:0]       req_stage,
   input  logic [6:0]       req_position,
   input  logic [63:0]      req_occupied_mask,
   input  logic             rsp_valid,
   input  logic [SQ_W-1:0]  rsp_read_value,
   output int               error_count,
   output int               pending_count,
   output int               result_count
);

   logic [SQ_W-1:0] square_lists [LISTS][SLOTS];
   logic [SQ_W-1:0] list_lengths [LISTS];
   logic [SQ_W-1:0] expected_values [$];

   function automatic int list_index(logic side, logic [6:0] stage);
      return side * SLOTS + (stage - 1);
   endfunction

   task automatic load_priority_order();
      for (int l = 0; l < LISTS; l++) begin
         for (int s = 0; s < SLOTS; s++)
            square_lists[l][s] = PRIO_TABLE[s];
         list_lengths[l] = INIT_LEN;
      end
   endtask

   task automatic prune_one_list(int l, logic [63:0] occupied);
      int len;
      int k;
      logic [SQ_W-1:0] sq;
      len = list_lengths[l] > SLOTS ? SLOTS : list_lengths[l];
      k = 0;
      while (k < len) begin
         sq = square_lists[l][k];
         if (sq >= 1 && sq <= 64 && occupied[sq - 1]) begin
            len--;
            for (int m = k; m < len; m++)
               square_lists[l][m] = square_lists[l][m + 1];
         end else begin
            k++;
         end
      end
      list_lengths[l] = SQ_W'(len);
   endtask

   // Applies one command to the shadow lists and returns the value it reads.
   task automatic apply_command(logic [2:0] op, logic side, logic [6:0] stage,
                                logic [6:0] pos, logic [63:0] occupied,
                                output logic [SQ_W-1:0] value);
      bit stage_ok;
      bit pos_ok;
      int l;
      int first;
      logic [SQ_W-1:0] held;
      stage_ok = stage >= 1 && stage <= 64;
      pos_ok = pos >= 1 && pos <= 64;
      l = stage_ok ? list_index(side, stage) : 0;
      value = '0;
      case (op)
         OP_READ_LEN: begin
            if (stage_ok) value = list_lengths[l];
         end
         OP_READ_ENTRY: begin
            if (stage_ok && pos_ok) value = square_lists[l][pos - 1];
         end
         OP_TRANSPOSE: begin
            if (stage_ok && pos_ok && pos > 1) begin
               held = square_lists[l][pos - 2];
               square_lists[l][pos - 2] = square_lists[l][pos - 1];
               square_lists[l][pos - 1] = held;
            end
         end
         OP_MOVE_FRONT: begin
            if (stage_ok && pos_ok && pos > 1) begin
               held = square_lists[l][pos - 1];
               for (int i = pos - 1; i > 0; i--)
                  square_lists[l][i] = square_lists[l][i - 1];
               square_lists[l][0] = held;
            end
         end
         OP_PRUNE: begin
            first = stage == 0 ? 1 : stage;
            for (int sd = 0; sd < 2; sd++)
               for (int s = first; s <= 64; s++)
                  prune_one_list(sd * SLOTS + s - 1, occupied);
         end
         OP_REINIT: load_priority_order();
         default: ;
      endcase
   endtask

   assign pending_count = expected_values.size();

   initial begin
      error_count = 0;
      result_count = 0;
      load_priority_order();
   end

   always @(posedge clock) begin
      logic [SQ_W-1:0] want;
      if (reset) begin
         load_priority_order();
         expected_values.delete();
      end else begin
         // Results retire before a new transaction is queued behind them.
         if (rsp_valid) begin
            result_count++;
            if (expected_values.size() == 0) begin
               $error("result with no transaction outstanding, read_value=%0d",
                      rsp_read_value);
               error_count++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_read_value !== want) begin
                  $error("read_value mismatch: expected %0d, actual %0d", want,
                         rsp_read_value);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_command(req_opcode, req_side, req_stage, req_position,
                          req_occupied_mask, want);
            expected_values.push_back(want);
         end
      end
   end

endmodule

// ===== verif/tb_move_order_history_table.sv =====
// Testbench top for the move order history table: drives directed and random commands
// through the start/busy handshake and reports the checker's verdict.
// Depends on moht_pkg, move_order_history_table and moht_checker.
`timescale 1ns / 100ps

module tb_move_order_history_table;
   import moht_pkg::*;

   // Opcodes the block leaves undefined; they must read zero and change nothing.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_COMMANDS = 2000;
   // Prunes over every list and reinits are the costly commands, so the
   // limit is sized for a few hundred of those on top of the cheap commands.
   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_opcode;
   logic req_side;
   logic [6:0] req_stage;
   logic [6:0] req_position;
   logic [63:0] req_occupied_mask;
   logic rsp_valid;
   logic [SQ_W-1:0] rsp_read_value;

   int error_count;
   int pending_count;
   int result_count;
   int cycle_count;
   int prune_count;
   int reorder_count;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   move_order_history_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_side          (req_side),
      .req_stage         (req_stage),
      .req_position      (req_position),
      .req_occupied_mask (req_occupied_mask),
      .rsp_valid         (rsp_valid),
      .rsp_read_value    (rsp_read_value)
   );

   moht_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_side          (req_side),
      .req_stage         (req_stage),
      .req_position      (req_position),
      .req_occupied_mask (req_occupied_mask),
      .rsp_valid         (rsp_valid),
      .rsp_read_value    (rsp_read_value),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .result_count      (result_count)
   );

   // The watchdog ends a hung run. It counts every cycle, including the fill after
   // reset and every long prune.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  pending_count);
         $display("tb_move_order_history_table: errors");
         $finish;
      end
   end

   // Presents one command and holds it until the edge at which the block takes it.
   // Start stays high afterwards; the caller lowers it only when a gap follows, so
   // back-to-back commands never see start dropped and raised in one time step.
   task automatic issue_command(logic [2:0] op, logic side, logic [6:0] stage,
                                logic [6:0] pos, logic [63:0] occupied);
      start <= 1'b1;
      req_opcode <= op;
      req_side <= side;
      req_stage <= stage;
      req_position <= pos;
      req_occupied_mask <= occupied;
      if (op == OP_PRUNE) prune_count++;
      if (op == OP_TRANSPOSE || op == OP_MOVE_FRONT) reorder_count++;
      do @(posedge clock); while (busy);
   endtask

   // Idle gap with start low.
   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clock);
   endtask

   function automatic logic [63:0] random_mask();
      logic [63:0] m;
      m = {$urandom, $urandom};
      // Mostly sparse masks, as a game fills the board a few squares at a time.
      case ($urandom_range(3, 0))
         0: m = m & {$urandom, $urandom} & {$urandom, $urandom};
         1: m = 64'd1 << $urandom_range(63, 0);
         2: m = m & {$urandom, $urandom};
         default: ;
      endcase
      return m;
   endfunction

   // Stage values: mostly legal, now and then out of range on either side.
   function automatic logic [6:0] random_stage();
      case ($urandom_range(19, 0))
         0: return 7'd0;
         1: return 7'($urandom_range(127, 65));
         default: return 7'($urandom_range(64, 1));
      endcase
   endfunction

   function automatic logic [6:0] random_position();
      case ($urandom_range(19, 0))
         0: return 7'd0;
         1: return 7'($urandom_range(127, 65));
         2: return 7'd1;
         3: return 7'd64;
         default: return 7'($urandom_range(64, 1));
      endcase
   endfunction

   initial begin
      logic [2:0] op;
      logic [6:0] stage;
      int pick;
      bit quiet;
      cycle_count = 0;
      prune_count = 0;
      reorder_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= OP_READ_LEN;
      req_side <= 1'b0;
      req_stage <= 7'd1;
      req_position <= 7'd1;
      req_occupied_mask <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: fresh lists, range edges, front-slot no-ops and tails.
      issue_command(OP_READ_LEN, 1'b0, 7'd1, 7'd1, '0);
      issue_command(OP_READ_LEN, 1'b1, 7'd64, 7'd1, '0);
      issue_command(OP_READ_LEN, 1'b0, 7'd0, 7'd1, '0);
      issue_command(OP_READ_ENTRY, 1'b0, 7'd1, 7'd1, '0);
      issue_command(OP_READ_ENTRY, 1'b1, 7'd64, 7'd64, '0);
      issue_command(OP_READ_ENTRY, 1'b0, 7'd65, 7'd3, '0);
      issue_command(OP_READ_ENTRY, 1'b1, 7'd127, 7'd0, '0);
      issue_command(OP_READ_ENTRY, 1'b0, 7'd5, 7'd127, '0);
      issue_command(OP_TRANSPOSE, 1'b0, 7'd3, 7'd1, '0);
      issue_command(OP_TRANSPOSE, 1'b0, 7'd3, 7'd64, '0);
      issue_command(OP_READ_ENTRY, 1'b0, 7'd3, 7'd63, '0);
      issue_command(OP_MOVE_FRONT, 1'b1, 7'd64, 7'd64, '0);
      issue_command(OP_MOVE_FRONT, 1'b1, 7'd64, 7'd1, '0);
      issue_command(OP_MOVE_FRONT, 1'b1, 7'd0, 7'd9, '0);
      issue_command(OP_READ_ENTRY, 1'b1, 7'd64, 7'd1, '0);
      issue_command(OP_PRUNE, 1'b0, 7'd100, 7'd1, '1);
      issue_command(OP_PRUNE, 1'b0, 7'd64, 7'd1, '1);
      issue_command(OP_READ_LEN, 1'b1, 7'd64, 7'd1, '0);
      issue_command(OP_READ_ENTRY, 1'b1, 7'd64, 7'd2, '0);
      issue_command(OP_PRUNE, 1'b1, 7'd0, 7'd1, 64'h8000_0000_0000_0001);
      issue_command(OP_PRUNE, 1'b0, 7'd50, 7'd1, '0);
      issue_command(OP_SPARE_LO, 1'b0, 7'd2, 7'd2, '1);
      issue_command(OP_SPARE_HI, 1'b1, 7'd2, 7'd2, '1);
      issue_command(OP_REINIT, 1'b0, 7'd1, 7'd1, '0);
      issue_command(OP_READ_LEN, 1'b1, 7'd64, 7'd1, '0);

      // Random part. Reads and reorders dominate; prunes mostly start late in the
      // game to bound their cost, and reinit is rare so lists drift far from reset.
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         quiet = n >= RANDOM_COMMANDS * 9 / 10;
         pick = $urandom_range(99, 0);
         stage = random_stage();
         if (pick < 25) op = OP_READ_ENTRY;
         else if (pick < 38) op = OP_READ_LEN;
         else if (pick < 62) op = OP_TRANSPOSE;
         else if (pick < 90) op = OP_MOVE_FRONT;
         else if (pick < 96) begin
            op = OP_PRUNE;
            if ($urandom_range(3, 0) != 0) stage = 7'($urandom_range(64, 44));
         end else if (pick < 97) op = OP_REINIT;
         else op = $urandom_range(1, 0) ? OP_SPARE_LO : OP_SPARE_HI;
         issue_command(op, 1'($urandom), stage, random_position(), random_mask());
         if (!quiet && $urandom_range(2, 0) == 0) idle_burst();
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d results, %0d prunes and %0d reorders in %0d cycles",
               result_count, prune_count, reorder_count, cycle_count);
      if (error_count == 0) begin
         $display("tb_move_order_history_table: clean");
      end else begin
         $display("tb_move_order_history_table: errors");
      end
      $finish;
   end

endmodule
